>>> design/masked_surface_extension_3d_core_defines.svh
// Assertion macros for the masked surface extension core.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef MASKED_SURFACE_EXTENSION_3D_CORE_DEFINES_SVH
`define MASKED_SURFACE_EXTENSION_3D_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MSX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msx check failed");

// next-cycle implication, disabled while reset is low
`define MSX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msx check failed");

`endif

>>> design/msx_pkg.sv
// Shared widths, register codes, weights and helpers for the surface extension core.
// No dependencies; used by every other module through scoped names.
package msx_pkg;

    localparam int DEF_MAX_NY = 256;
    localparam int DEF_MAX_NX = 256;
    localparam int DEF_MAX_NZ = 4096;

    localparam int VAL_W  = 16;
    localparam int ENT_W  = 17;
    localparam int W_W    = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 37;
    localparam int SUM_W  = 20;
    localparam int Q_W    = 17;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 13;
    localparam int SZ_W   = 17;

    localparam logic [CFG_IW-1:0] CFG_SIZE_Y = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SIZE_X = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Z = 2'd2;

    // Q1.15 distance weights
    localparam logic [W_W-1:0] W_FACE   = 16'd32768;
    localparam logic [W_W-1:0] W_EDGE   = 16'd23170;
    localparam logic [W_W-1:0] W_CORNER = 16'd18918;

    function automatic logic [W_W-1:0] weight(input logic [1:0] hops);
        logic [W_W-1:0] w;
        case (hops)
            2'd1:    w = W_FACE;
            2'd2:    w = W_EDGE;
            2'd3:    w = W_CORNER;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v,
                                                   input logic [SZ_W-1:0] maxv);
        logic [SZ_W-1:0] r;
        if (v == '0) begin
            r = SZ_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> design/msx_store.sv
// Window store: simple dual-port synchronous RAM, one write and one registered read.
// Depends on msx_pkg for the entry width default.
module msx_store #(
    parameter int DEPTH = 131587,
    parameter int DW    = msx_pkg::ENT_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/msx_div.sv
// Iterative restoring divider: signed sum over unsigned weight total, truncating.
// One quotient bit per cycle; depends on msx_pkg for widths.
module msx_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [msx_pkg::ACC_W-1:0]  i_num,
    input  logic        [msx_pkg::SUM_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [msx_pkg::VAL_W-1:0]  o_quot
);

    localparam int AW = msx_pkg::ACC_W;
    localparam int QW = msx_pkg::Q_W;
    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic [QW-1:0] w_q_signed;
    logic          w_fit;

    assign w_fit = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
                r_neg  <= i_num[AW-1];
                r_rem  <= i_num[AW-1] ? AW'(-i_num) : AW'(i_num);
                r_den  <= AW'(i_den) << (QW - 1);
                r_q    <= '0;
            end else if (r_busy) begin
                // take one quotient bit, walk the divisor down
                if (w_fit) begin
                    r_rem <= r_rem - r_den;
                end
                r_q   <= {r_q[QW-2:0], w_fit};
                r_den <= r_den >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign w_q_signed = r_neg ? (~r_q + QW'(1)) : r_q;
    assign o_quot     = $signed(w_q_signed[msx_pkg::VAL_W-1:0]);
    assign o_done     = r_done;

endmodule

>>> design/masked_surface_extension_3d_core.sv
// Top level of the masked surface extension core: control, neighbour sweep, accumulation.
// Depends on msx_pkg, msx_store, msx_div and the assertion macro header.
//
// Usage: voxels enter on the s_axis channel in raster order (y fastest, then x,
// then z); tdata carries the CT value, tuser bit 0 the solid bit and bit 1 the
// drain marker. Results leave on m_axis: tdata the extended value, tuser the
// flag, tlast the final voxel of the volume. Sizes are set by the user through
// the cfg channel while the core is idle; the core itself does not enforce
// this. Each valid write to a size register restarts the stream. Each voxel
// is emitted size_y*size_x+size_y+1 transactions after it entered; drain
// transactions after the last voxel push the tail out.
// Flow: a transaction that emits nothing leaves the core idle and ready for
// the next. One that emits holds off input through 27 neighbour reads on the
// single store read port, the pipeline and the output register, and longer
// when the weighted mean is formed by the 17-step divider. Input is held off
// while a cfg write is offered and in the cycle after it. Reset restores
// 256x256x256 sizes and empties the stream; the store is not cleared.
// A stalled receiver holds the result in the output register; the next input
// transaction is still taken and its result waits until the output register frees.
`include "masked_surface_extension_3d_core_defines.svh"
module masked_surface_extension_3d_core #(
    parameter int MAX_NY = msx_pkg::DEF_MAX_NY,
    parameter int MAX_NX = msx_pkg::DEF_MAX_NX,
    parameter int MAX_NZ = msx_pkg::DEF_MAX_NZ
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [15:0]                   i_s_axis_tdata,  // ct_value
    input  logic [1:0]                    i_s_axis_tuser,  // in_solid, is_drain
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [15:0]                   o_m_axis_tdata,  // ext_value
    output logic                          o_m_axis_tuser,  // ext_flag
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [msx_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [msx_pkg::CFG_DW-1:0]    i_cfg_data
);

    localparam int DEPTH = 2 * MAX_NY * MAX_NX + 2 * MAX_NY + 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW + 2;
    localparam int YW    = $clog2(MAX_NY);
    localparam int XW    = $clog2(MAX_NX);
    localparam int NYW   = $clog2(MAX_NY + 1);
    localparam int NXW   = $clog2(MAX_NX + 1);
    localparam int ZW    = $clog2(MAX_NZ + 1);
    localparam int PW    = NYW + NXW;
    localparam int LW    = $clog2(MAX_NY * MAX_NX + MAX_NY + 2);
    localparam int VW    = msx_pkg::VAL_W;
    localparam int EW    = msx_pkg::ENT_W;
    localparam int ACW   = msx_pkg::ACC_W;
    localparam int SMW   = msx_pkg::SUM_W;
    localparam int PRW   = msx_pkg::PROD_W;
    localparam int SZW   = msx_pkg::SZ_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state r_state;

    logic [8:0]   r_size_y;
    logic [8:0]   r_size_x;
    logic [12:0]  r_size_z;
    logic         r_settle;
    logic [PW-1:0] r_plane;

    logic [YW-1:0] r_in_y, r_out_y, n_in_y, n_out_y;
    logic [XW-1:0] r_in_x, r_out_x, n_in_x, n_out_x;
    logic [ZW-1:0] r_in_z, r_out_z, n_in_z, n_out_z;
    logic [LW-1:0] r_fill;
    logic [AW-1:0] r_wptr, r_optr;

    logic [1:0]    r_dy, r_dx, r_dz;
    logic          r_rd_valid;
    logic [1:0]    r_rd_dist;
    logic          r_pr_valid;
    logic signed [PRW-1:0] r_pr_tw;
    logic [msx_pkg::W_W-1:0] r_pr_w;
    logic signed [ACW-1:0] r_acc_t;
    logic [SMW-1:0] r_acc_s;
    logic [EW-1:0]  r_cen;

    logic [VW-1:0] r_res;
    logic          r_res_flag;
    logic          r_out_valid;
    logic [VW-1:0] r_out_data;
    logic          r_out_flag;
    logic          r_out_last;
    logic          r_div_start;

    logic [NYW-1:0] w_ny;
    logic [NXW-1:0] w_nx;
    logic [ZW-1:0]  w_nz;
    logic [LW-1:0]  w_lag;
    logic           w_in_acc;
    logic           w_open;
    logic           w_drain;
    logic           w_wr_en;
    logic           w_emit;
    logic           w_border;
    logic           w_last;
    logic           w_sweep_end;
    logic           w_out_free;
    logic [1:0]     w_dist;
    logic [AW-1:0]  w_nbr_addr;
    logic [EW-1:0]  w_rd_data;
    logic [msx_pkg::W_W-1:0] w_rd_w;
    logic           w_div_done;
    logic signed [VW-1:0] w_quot;
    logic signed [SW-1:0] w_off_y, w_off_x, w_off_z, w_sum;
    logic signed [SW-1:0] w_one_s, w_ny_s, w_pl_s, w_depth_s;
    logic [NYW-1:0] w_in_y_inc, w_out_y_inc;
    logic [NXW-1:0] w_in_x_inc, w_out_x_inc;

    // effective sizes
    assign w_ny = NYW'(msx_pkg::clamp_size(SZW'(r_size_y), SZW'(MAX_NY)));
    assign w_nx = NXW'(msx_pkg::clamp_size(SZW'(r_size_x), SZW'(MAX_NX)));
    assign w_nz = ZW'(msx_pkg::clamp_size(SZW'(r_size_z), SZW'(MAX_NZ)));
    assign w_lag = LW'(r_plane) + LW'(w_ny) + LW'(1);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_settle && !i_cfg_valid;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_drain   = i_s_axis_tuser[1];
    assign w_open    = (r_in_z < w_nz);
    assign w_wr_en   = w_in_acc && w_open && !w_drain;
    assign w_emit    = (r_fill >= w_lag);

    // raster advance of input and output coordinates
    always_comb begin
        w_in_y_inc = NYW'(r_in_y) + NYW'(1);
        w_in_x_inc = NXW'(r_in_x) + NXW'(1);
        n_in_y = r_in_y;
        n_in_x = r_in_x;
        n_in_z = r_in_z;
        if (w_in_y_inc >= w_ny) begin
            n_in_y = '0;
            if (w_in_x_inc >= w_nx) begin
                n_in_x = '0;
                n_in_z = r_in_z + ZW'(1);
            end else begin
                n_in_x = XW'(w_in_x_inc);
            end
        end else begin
            n_in_y = YW'(w_in_y_inc);
        end
    end

    always_comb begin
        w_out_y_inc = NYW'(r_out_y) + NYW'(1);
        w_out_x_inc = NXW'(r_out_x) + NXW'(1);
        n_out_y = r_out_y;
        n_out_x = r_out_x;
        n_out_z = r_out_z;
        if (w_out_y_inc >= w_ny) begin
            n_out_y = '0;
            if (w_out_x_inc >= w_nx) begin
                n_out_x = '0;
                n_out_z = r_out_z + ZW'(1);
            end else begin
                n_out_x = XW'(w_out_x_inc);
            end
        end else begin
            n_out_y = YW'(w_out_y_inc);
        end
    end

    assign w_last = (w_out_y_inc == w_ny) && (w_out_x_inc == w_nx)
                 && ((r_out_z + ZW'(1)) == w_nz);
    assign w_border = (r_out_y == '0) || (r_out_x == '0) || (r_out_z == '0)
                   || (w_out_y_inc == w_ny) || (w_out_x_inc == w_nx)
                   || ((r_out_z + ZW'(1)) == w_nz);

    // neighbour address: centre pointer plus signed offset, wrapped once
    assign w_one_s   = $signed(SW'(1));
    assign w_ny_s    = $signed(SW'(w_ny));
    assign w_pl_s    = $signed(SW'(r_plane));
    assign w_depth_s = $signed(SW'(DEPTH));

    always_comb begin
        w_off_y = (r_dy == 2'd0) ? -w_one_s : ((r_dy == 2'd2) ? w_one_s : '0);
        w_off_x = (r_dx == 2'd0) ? -w_ny_s  : ((r_dx == 2'd2) ? w_ny_s  : '0);
        w_off_z = (r_dz == 2'd0) ? -w_pl_s  : ((r_dz == 2'd2) ? w_pl_s  : '0);
        w_sum   = $signed(SW'(r_optr)) + w_off_y + w_off_x + w_off_z;
        if (w_sum < 0) begin
            w_nbr_addr = AW'(w_sum + w_depth_s);
        end else if (w_sum >= w_depth_s) begin
            w_nbr_addr = AW'(w_sum - w_depth_s);
        end else begin
            w_nbr_addr = AW'(w_sum);
        end
    end

    assign w_dist = 2'(r_dy != 2'd1) + 2'(r_dx != 2'd1) + 2'(r_dz != 2'd1);
    assign w_sweep_end = (r_dy == 2'd2) && (r_dx == 2'd2) && (r_dz == 2'd2);
    assign w_rd_w = w_rd_data[EW-1] ? msx_pkg::weight(r_rd_dist) : '0;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // the write of an item lands before its sweep starts, so no forwarding
    msx_store #(
        .DEPTH (DEPTH),
        .DW    (EW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data ({i_s_axis_tuser[0], i_s_axis_tdata}),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (w_nbr_addr),
        .o_rd_data (w_rd_data)
    );

    msx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_acc_t),
        .i_den   (r_acc_s),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // read, weight and accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_pr_valid <= 1'b0;
        end else begin
            r_rd_valid <= (r_state == ST_READ);
            r_rd_dist  <= w_dist;
            r_pr_valid <= r_rd_valid;
            r_pr_w     <= w_rd_w;
            r_pr_tw    <= PRW'($signed(w_rd_data[VW-1:0]) * $signed({1'b0, w_rd_w}));
            if (r_rd_valid && (r_rd_dist == 2'd0)) begin
                r_cen <= w_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= PW'(w_ny) * PW'(w_nx);
        if (w_in_acc && w_emit && (!w_open || !w_drain)) begin
            r_acc_t <= '0;
            r_acc_s <= '0;
        end else if (r_pr_valid) begin
            r_acc_t <= r_acc_t + ACW'(r_pr_tw);
            r_acc_s <= r_acc_s + SMW'(r_pr_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size_y    <= 9'd256;
            r_size_x    <= 9'd256;
            r_size_z    <= 13'd256;
            r_settle    <= 1'b1;
            r_in_y      <= '0;
            r_in_x      <= '0;
            r_in_z      <= '0;
            r_out_y     <= '0;
            r_out_x     <= '0;
            r_out_z     <= '0;
            r_fill      <= '0;
            r_wptr      <= '0;
            r_optr      <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_settle    <= i_cfg_valid;
            // start the divider when the mean has to be formed
            r_div_start <= (r_state == ST_WAIT) && !i_cfg_valid && !r_rd_valid
                        && !r_pr_valid && !w_border && !r_cen[EW-1] && (r_acc_s != '0);
            // the finishing state refills the output register itself
            if (r_out_valid && i_m_axis_tready && !(r_state == ST_FIN && !i_cfg_valid)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    msx_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data[8:0];
                    msx_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data[8:0];
                    msx_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index == msx_pkg::CFG_SIZE_Y || i_cfg_index == msx_pkg::CFG_SIZE_X
                    || i_cfg_index == msx_pkg::CFG_SIZE_Z) begin
                    r_in_y  <= '0;
                    r_in_x  <= '0;
                    r_in_z  <= '0;
                    r_out_y <= '0;
                    r_out_x <= '0;
                    r_out_z <= '0;
                    r_fill  <= '0;
                    r_wptr  <= '0;
                    r_optr  <= '0;
                end
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        // drop a drain while the volume is still coming in
                        if (w_in_acc && (!w_open || !w_drain)) begin
                            if (w_open) begin
                                r_in_y <= n_in_y;
                                r_in_x <= n_in_x;
                                r_in_z <= n_in_z;
                                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
                            end
                            if (w_emit) begin
                                r_dy    <= 2'd0;
                                r_dx    <= 2'd0;
                                r_dz    <= 2'd0;
                                r_state <= ST_READ;
                            end else begin
                                r_fill <= r_fill + LW'(1);
                            end
                        end
                    end
                    ST_READ: begin
                        if (r_dy != 2'd2) begin
                            r_dy <= r_dy + 2'd1;
                        end else begin
                            r_dy <= 2'd0;
                            if (r_dx != 2'd2) begin
                                r_dx <= r_dx + 2'd1;
                            end else begin
                                r_dx <= 2'd0;
                                r_dz <= r_dz + 2'd1;
                            end
                        end
                        if (w_sweep_end) begin
                            r_state <= ST_WAIT;
                        end
                    end
                    ST_WAIT: begin
                        if (!r_rd_valid && !r_pr_valid) begin
                            r_res <= r_cen[VW-1:0];
                            if (w_border) begin
                                r_res_flag <= 1'b0;
                                r_state    <= ST_FIN;
                            end else if (r_cen[EW-1]) begin
                                r_res_flag <= 1'b1;
                                r_state    <= ST_FIN;
                            end else if (r_acc_s == '0) begin
                                r_res_flag <= 1'b0;
                                r_state    <= ST_FIN;
                            end else begin
                                r_res_flag  <= 1'b1;
                                r_state     <= ST_DIV;
                            end
                        end
                    end
                    ST_DIV: begin
                        if (w_div_done) begin
                            r_res   <= w_quot;
                            r_state <= ST_FIN;
                        end
                    end
                    ST_FIN: begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= r_res;
                            r_out_flag  <= r_res_flag;
                            r_out_last  <= w_last;
                            r_state     <= ST_IDLE;
                            if (w_last) begin
                                r_in_y  <= '0;
                                r_in_x  <= '0;
                                r_in_z  <= '0;
                                r_out_y <= '0;
                                r_out_x <= '0;
                                r_out_z <= '0;
                                r_fill  <= '0;
                                r_wptr  <= '0;
                                r_optr  <= '0;
                            end else begin
                                r_out_y <= n_out_y;
                                r_out_x <= n_out_x;
                                r_out_z <= n_out_z;
                                r_optr  <= (r_optr == AW'(DEPTH - 1)) ? '0 : r_optr + AW'(1);
                            end
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flag;
    assign o_m_axis_tlast  = r_out_last;

    `MSX_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, !r_settle, r_fill <= w_lag)
    `MSX_ASSERT_NOW(a_read_addr, i_clk, i_rst_n, r_state == ST_READ,
                    w_nbr_addr < AW'(DEPTH))
    `MSX_ASSERT_NOW(a_div_owner, i_clk, i_rst_n, w_div_done, r_state == ST_DIV)
    `MSX_ASSERT_NXT(a_fin_hold, i_clk, i_rst_n,
                    r_state == ST_FIN && r_out_valid && !i_m_axis_tready && !i_cfg_valid,
                    r_state == ST_FIN)

endmodule

>>> tb/msx_checker.sv
// Watches the voxel, result and configuration channels of the surface extension core.
// Predicts every result from its own volume window copy; depends on msx_pkg.
`timescale 1ns / 100ps
module msx_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    input  logic                       i_s_axis_tready,
    input  logic [15:0]                i_s_axis_tdata,
    input  logic [1:0]                 i_s_axis_tuser,
    input  logic                       i_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic [15:0]                i_m_axis_tdata,
    input  logic                       i_m_axis_tuser,
    input  logic                       i_m_axis_tlast,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [msx_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [msx_pkg::CFG_DW-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    localparam int NY_MAX = 256;
    localparam int NX_MAX = 256;
    localparam int NZ_MAX = 4096;
    localparam int WIN_DEPTH = 2 * NY_MAX * NX_MAX + 2 * NY_MAX + 3;

    typedef struct packed {
        logic [15:0] value;
        logic        flag;
        logic        last;
    } voxel_out_t;

    logic [16:0] vol_win [WIN_DEPTH];
    int unsigned reg_y, reg_x, reg_z;
    int unsigned iy, ix, iz, oy, ox, oz, fill;
    voxel_out_t  ext_q[$];

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint face_weight(int hops);
        case (hops)
            1:       return 32768;
            2:       return 23170;
            3:       return 18918;
            default: return 0;
        endcase
    endfunction

    task automatic restart_stream();
        iy = 0; ix = 0; iz = 0;
        oy = 0; ox = 0; oz = 0;
        fill = 0;
    endtask

    task automatic step_coord(inout int unsigned y, inout int unsigned x,
                              inout int unsigned z, input int unsigned ny,
                              input int unsigned nx);
        y++;
        if (y >= ny) begin
            y = 0;
            x++;
            if (x >= nx) begin
                x = 0;
                z++;
            end
        end
    endtask

    // one accepted voxel transaction; pushes the result it causes, if any
    task automatic predict_extension(logic [15:0] ct, logic solid, logic drain);
        int unsigned ny, nx, nz, lag;
        longint n, idx, s, t;
        logic [16:0] cen, e;
        logic signed [15:0] res;
        logic flag, last;
        voxel_out_t r;
        ny = clamp_dim(reg_y, NY_MAX);
        nx = clamp_dim(reg_x, NX_MAX);
        nz = clamp_dim(reg_z, NZ_MAX);
        lag = ny * nx + ny + 1;
        if (iz < nz) begin
            if (drain) return;
            n = longint'(iy) + ny * (longint'(ix) + nx * longint'(iz));
            vol_win[n % WIN_DEPTH] = {solid, ct};
            step_coord(iy, ix, iz, ny, nx);
        end
        fill++;
        if (fill <= lag) return;
        fill--;
        n = longint'(oy) + ny * (longint'(ox) + nx * longint'(oz));
        cen = vol_win[n % WIN_DEPTH];
        res = cen[15:0];
        flag = 1'b0;
        if (oy == 0 || ox == 0 || oz == 0 || oy == ny - 1 || ox == nx - 1 || oz == nz - 1) begin
            flag = 1'b0;
        end else if (cen[16]) begin
            flag = 1'b1;
        end else begin
            s = 0;
            t = 0;
            for (int dz = -1; dz <= 1; dz++)
                for (int dx = -1; dx <= 1; dx++)
                    for (int dy = -1; dy <= 1; dy++) begin
                        idx = (n + dy + longint'(ny) * (dx + longint'(nx) * dz)) % WIN_DEPTH;
                        e = vol_win[idx];
                        if (e[16]) begin
                            s += face_weight((dy != 0) + (dx != 0) + (dz != 0));
                            t += face_weight((dy != 0) + (dx != 0) + (dz != 0))
                                 * longint'($signed(e[15:0]));
                        end
                    end
            if (s != 0) begin
                res = 16'(t / s);
                flag = 1'b1;
            end
        end
        last = (oy == ny - 1 && ox == nx - 1 && oz == nz - 1);
        step_coord(oy, ox, oz, ny, nx);
        if (last) restart_stream();
        r.value = res;
        r.flag = flag;
        r.last = last;
        ext_q.push_back(r);
    endtask

    initial begin
        foreach (vol_win[k]) vol_win[k] = '0;
        reg_y = 256;
        reg_x = 256;
        reg_z = 256;
        restart_stream();
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        voxel_out_t exp_r;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    msx_pkg::CFG_SIZE_Y: begin reg_y = i_cfg_data[8:0]; restart_stream(); end
                    msx_pkg::CFG_SIZE_X: begin reg_x = i_cfg_data[8:0]; restart_stream(); end
                    msx_pkg::CFG_SIZE_Z: begin reg_z = i_cfg_data[12:0]; restart_stream(); end
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (ext_q.size() == 0) begin
                    $error("unexpected result value=%0d flag=%0b last=%0b",
                           $signed(i_m_axis_tdata), i_m_axis_tuser, i_m_axis_tlast);
                    o_errors++;
                end else begin
                    exp_r = ext_q.pop_front();
                    if (exp_r.value !== i_m_axis_tdata) begin
                        $error("ext_value expected %0d actual %0d",
                               $signed(exp_r.value), $signed(i_m_axis_tdata));
                        o_errors++;
                    end
                    if (exp_r.flag !== i_m_axis_tuser) begin
                        $error("ext_flag expected %0b actual %0b", exp_r.flag, i_m_axis_tuser);
                        o_errors++;
                    end
                    if (exp_r.last !== i_m_axis_tlast) begin
                        $error("last expected %0b actual %0b", exp_r.last, i_m_axis_tlast);
                        o_errors++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_extension(i_s_axis_tdata, i_s_axis_tuser[0], i_s_axis_tuser[1]);
        end
        o_pending = ext_q.size();
    end
endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the masked surface extension core.
// Depends on msx_pkg, the core and msx_checker.
`timescale 1ns / 100ps
module tb_top;

    localparam int CYCLE_LIMIT = 3000000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_valid, s_ready;
    logic [15:0]                 s_data;
    logic [1:0]                  s_user;
    logic                        m_valid, m_ready, m_user, m_last;
    logic [15:0]                 m_data;
    logic                        cfg_valid, cfg_ready;
    logic [msx_pkg::CFG_IW-1:0]  cfg_index;
    logic [msx_pkg::CFG_DW-1:0]  cfg_data;
    int                          errors, pending;
    int                          cycles;
    int                          voxels_sent;
    bit                          hold_req;
    bit                          calm;
    logic                        m_fire;

    masked_surface_extension_3d_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    msx_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .i_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    always @(posedge i_clk) m_fire <= m_valid && m_ready;

    // result side: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int gap;
        gap = 0;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if ($urandom_range(0, 199) == 0) calm = ~calm;
            if (m_fire) gap = calm ? 0 : $urandom_range(0, 16);
            m_ready <= (gap == 0);
            if (gap > 0) gap--;
        end
    end

    // drive one voxel transaction; valid stays up when no gap is drawn
    task automatic send_voxel(logic [15:0] ct, logic solid, logic drain);
        int gap;
        bit rdy;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_data <= ct;
        s_user <= {drain, solid};
        s_valid <= 1'b1;
        do begin
            #1 rdy = s_ready;
            @(posedge i_clk);
        end while (!rdy);
        @(negedge i_clk);
        voxels_sent++;
    endtask

    task automatic write_reg(logic [msx_pkg::CFG_IW-1:0] idx, logic [msx_pkg::CFG_DW-1:0] val);
        bit rdy;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do begin
            #1 rdy = cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_ct();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one volume: configure, stream voxels (with ignored drains mixed in), then flush.
    // A partial count leaves the volume open; the next register write restarts it.
    task automatic run_volume(int wy, int wx, int wz, int partial, bit centre_case);
        int ny, nx, nz, total, lag, density;
        ny = (wy[8:0] == 0) ? 1 : (wy[8:0] > 256 ? 256 : wy[8:0]);
        nx = (wx[8:0] == 0) ? 1 : (wx[8:0] > 256 ? 256 : wx[8:0]);
        nz = (wz[12:0] == 0) ? 1 : (wz[12:0] > 4096 ? 4096 : wz[12:0]);
        lag = ny * nx + ny + 1;
        total = (partial > 0) ? partial : ny * nx * nz;
        density = $urandom_range(0, 100);
        settle();
        write_reg(msx_pkg::CFG_SIZE_Y, msx_pkg::CFG_DW'(wy));
        write_reg(msx_pkg::CFG_SIZE_X, msx_pkg::CFG_DW'(wx));
        write_reg(msx_pkg::CFG_SIZE_Z, msx_pkg::CFG_DW'(wz));
        for (int i = 0; i < total; i++) begin
            if (!centre_case && $urandom_range(0, 9) == 0)
                send_voxel(16'($urandom), 1'($urandom), 1'b1);
            if (centre_case)
                send_voxel((i == 13) ? 16'h1234 : ((i % 2) ? 16'h7FFF : 16'h8000),
                           (i != 13), 1'b0);
            else
                send_voxel(pick_ct(), $urandom_range(0, 99) < density, 1'b0);
        end
        if (partial == 0) begin
            // voxels offered past the end act as drains
            for (int i = 0; i < lag; i++)
                send_voxel(pick_ct(), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int sz;
        int sent0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = '0;
        cfg_valid = 1'b0;
        cfg_index = msx_pkg::CFG_SIZE_Y;
        cfg_data = '0;
        hold_req = 1'b0;
        calm = 1'b0;
        voxels_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // solid shell around a non-solid centre, values at both extremes
        run_volume(3, 3, 3, 0, 1'b1);
        // zero sizes count as one
        run_volume(0, 0, 1, 0, 1'b0);
        run_volume(1, 0, 0, 0, 1'b0);
        // long stall on the result side while the volume streams in
        sent0 = voxels_sent;
        fork
            run_volume(4, 4, 4, 0, 1'b0);
            begin
                wait (voxels_sent >= sent0 + 40);
                hold_req = 1'b1;
            end
        join
        // oversize and maximum sizes
        run_volume(511, 1, 1, 12, 1'b0);
        run_volume(1, 511, 1, 0, 1'b0);
        run_volume(1, 1, 8191, 12, 1'b0);
        run_volume(2, 2, 4096, 20, 1'b0);
        while (voxels_sent < 1150) begin
            sz = $urandom_range(1, 5);
            run_volume($urandom_range(1, 6), $urandom_range(1, 6), sz, 0, 1'b0);
        end
        settle();
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

>>> masked_surface_extension_3d_core.f
+incdir+design
design/msx_pkg.sv
design/msx_store.sv
design/msx_div.sv
design/masked_surface_extension_3d_core.sv
tb/msx_checker.sv
tb/tb_top.sv
